@@ rtl/core/lfu_pkg.sv @@
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared widths, constants, controller state type and the command and
// status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int KEY_W     = 32;
  localparam int CNT_W     = 16;
  localparam int STAMP_W   = 32;
  localparam int HITS_W    = 32;
  localparam int CAP_W     = 7;
  localparam int ENTRIES_DEFAULT = 64;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;
  localparam logic [CNT_W-1:0] COUNT_MAX = 16'hFFFF;
  localparam logic [CNT_W-1:0] COUNT_ONE = 16'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic start;
    logic issue;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic occ_zero;
    logic last_issue;
    logic out_free;
  } status_t;

endpackage

@@ rtl/core/lfu_ram.sv @@
// ----------------------------------------------------------------------------
// lfu_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module lfu_ram #(
  parameter int WIDTH = 80,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/lfu_ctrl.sv @@
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer for one access: accept, scan the filled slots and drain the last
// read (skipped when empty), then commit the update and load the result word.
// ----------------------------------------------------------------------------
module lfu_ctrl
  import lfu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = status.occ_zero ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status.last_issue) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: state_next = ST_FINISH;
      ST_FINISH: begin
        if (status.out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.start = in_valid;
      end
      ST_SCAN:   cmd.issue  = 1'b1;
      ST_DRAIN:  cmd        = '0;
      ST_FINISH: cmd.finish = status.out_free;
      default:   cmd        = '0;
    endcase
  end

endmodule

@@ rtl/core/lfu_dp.sv @@
// ----------------------------------------------------------------------------
// lfu_dp
// Datapath: slot RAM, fill count, counters, key match and victim search
// over the scanned slots, and the result register.
// ----------------------------------------------------------------------------
module lfu_dp
  import lfu_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst,
  input  cmd_t                      cmd,
  output status_t                   status,
  input  logic signed [KEY_W-1:0]   key,
  input  logic                      cfg_write,
  input  logic [CAP_W-1:0]          cfg_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      hit,
  output logic                      evicted,
  output logic signed [KEY_W-1:0]   evicted_key,
  output logic [HITS_W-1:0]         hit_total
);

  localparam int IW = $clog2(ENTRIES);
  localparam int OW = $clog2(ENTRIES + 1);
  localparam int MW = (OW > CAP_W) ? OW : CAP_W;
  localparam int RW = KEY_W + CNT_W + STAMP_W;

  logic [CAP_W-1:0]   capacity;
  logic [OW-1:0]      occ;
  logic [STAMP_W-1:0] order_cnt;
  logic [HITS_W-1:0]  hit_cnt;
  logic [KEY_W-1:0]   key_r;
  logic [IW-1:0]      idx;
  logic               rd_vld;
  logic [IW-1:0]      rd_idx;

  logic               match;
  logic [IW-1:0]      match_idx;
  logic [CNT_W-1:0]   match_cnt;
  logic               best_vld;
  logic [IW-1:0]      best_idx;
  logic [CNT_W-1:0]   best_cnt;
  logic [STAMP_W-1:0] best_age;
  logic [KEY_W-1:0]   best_key;

  logic [RW-1:0]      rdata;
  logic [KEY_W-1:0]   r_key;
  logic [CNT_W-1:0]   r_cnt;
  logic [STAMP_W-1:0] r_stamp;
  logic [STAMP_W-1:0] r_age;
  logic               better;

  logic [MW-1:0]      cap_ext;
  logic [MW-1:0]      eff_cap;
  logic               evict;
  logic               wr_en;
  logic [IW-1:0]      wr_addr;
  logic [RW-1:0]      wr_data;
  logic [CNT_W-1:0]   wr_cnt;

  assign {r_key, r_cnt, r_stamp} = rdata;
  // Age is measured against the order counter as it will stand after this
  // access; the larger age is the older stamp.
  assign r_age  = order_cnt + STAMP_W'(1) - r_stamp;
  assign better = !best_vld || (r_cnt < best_cnt) ||
                  ((r_cnt == best_cnt) && (r_age > best_age));

  assign cap_ext = MW'(capacity);
  always_comb begin
    if (capacity == '0) begin
      eff_cap = MW'(1);
    end else if (cap_ext > MW'(ENTRIES)) begin
      eff_cap = MW'(ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign evict = (MW'(occ) >= eff_cap);

  // Filled slots always form a prefix, since a freed slot is refilled at
  // once, so the next free slot is the fill count itself.
  assign wr_cnt  = match ? (match_cnt + COUNT_ONE) : COUNT_ONE;
  assign wr_en   = cmd.finish && (!match || (match_cnt != COUNT_MAX));
  assign wr_addr = match ? match_idx : (evict ? best_idx : occ[IW-1:0]);
  assign wr_data = {key_r, wr_cnt, order_cnt};

  lfu_ram #(
    .WIDTH(RW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (wr_en),
    .waddr(wr_addr),
    .wdata(wr_data),
    .raddr(idx),
    .rdata(rdata)
  );

  assign status.occ_zero   = (occ == '0);
  assign status.last_issue = ((OW'(idx) + OW'(1)) == occ);
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity  <= CAP_RESET;
      occ       <= '0;
      order_cnt <= '0;
      hit_cnt   <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        capacity <= cfg_data;
      end
      rd_vld <= cmd.issue;
      if (cmd.finish) begin
        order_cnt <= order_cnt + STAMP_W'(1);
        if (match) begin
          hit_cnt <= hit_cnt + HITS_W'(1);
        end else if (!evict) begin
          occ <= occ + OW'(1);
        end
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      key_r    <= key;
      idx      <= '0;
      match    <= 1'b0;
      best_vld <= 1'b0;
    end else begin
      if (cmd.issue) begin
        idx <= idx + IW'(1);
      end
      if (rd_vld) begin
        if (r_key == key_r) begin
          match     <= 1'b1;
          match_idx <= rd_idx;
          match_cnt <= r_cnt;
        end
        if (better) begin
          best_vld <= 1'b1;
          best_idx <= rd_idx;
          best_cnt <= r_cnt;
          best_age <= r_age;
          best_key <= r_key;
        end
      end
    end
    rd_idx <= idx;
    if (cmd.finish) begin
      hit         <= match;
      evicted     <= !match && evict;
      evicted_key <= (!match && evict) ? best_key : '0;
      hit_total   <= match ? (hit_cnt + HITS_W'(1)) : hit_cnt;
    end
  end

endmodule

@@ rtl/core/lfu_cache_policy.sv @@
// An access walks the filled slots before its result is registered; an empty
// cache skips the walk. A key is accepted only while idle, so a new word waits
// until the last access has loaded its result word, and that load waits while
// an earlier result word is still pending. The single slot RAM read port has
// the key match and victim search walk one filled slot per cycle. Reset clears
// the fill count, counters and result valid flag and sets capacity to 64.
// ----------------------------------------------------------------------------
// lfu_cache_policy
// Fully associative least-frequently-used key cache with oldest-first
// tie-break among equal use counts.
// ----------------------------------------------------------------------------
module lfu_cache_policy
  import lfu_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEFAULT
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_write,
  input  logic [CAP_W-1:0]        cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [KEY_W-1:0] key,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    hit,
  output logic                    evicted,
  output logic signed [KEY_W-1:0] evicted_key,
  output logic [HITS_W-1:0]       hit_total
);

  cmd_t    cmd;
  status_t status;

  lfu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  lfu_dp #(
    .ENTRIES(ENTRIES)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .key        (key),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .evicted    (evicted),
    .evicted_key(evicted_key),
    .hit_total  (hit_total)
  );

endmodule

@@ rtl/core/lfu_chk.sv @@
// ----------------------------------------------------------------------------
// lfu_chk
// Port-level checks on the cache, attached to the top level by a bind.
// ----------------------------------------------------------------------------
module lfu_chk
  import lfu_pkg::*;
(
  input logic                    clk,
  input logic                    rst,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    hit,
  input logic                    evicted,
  input logic signed [KEY_W-1:0] evicted_key,
  input logic [HITS_W-1:0]       hit_total
);

  // A hit never evicts anything.
  a_hit_no_evict: assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> !evicted)
    else $error("hit reported together with an eviction");

  // Without an eviction the evicted key field reads as zero.
  a_evkey_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted |-> evicted_key == '0)
    else $error("evicted key not zero without eviction");

  // An accepted word keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new word accepted straight after another");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(hit_total) && $stable(hit))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind lfu_cache_policy lfu_chk u_lfu_chk (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .hit        (hit),
  .evicted    (evicted),
  .evicted_key(evicted_key),
  .hit_total  (hit_total)
);

@@ sim/lfu_cache_policy_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lfu_cache_policy_tb
// Drives key accesses through the LFU cache and checks each result word
// against a behavioural cache kept in the bench. A short directed plan covers
// the key extremes, a run of repeated hits and the capacity corner values. A
// randomised part follows with skewed working sets under changing capacities,
// and random idling on both handshakes.
// ----------------------------------------------------------------------------
module lfu_cache_policy_tb;
  import lfu_pkg::*;

  localparam int ENTRIES = ENTRIES_DEFAULT;
  localparam int RANDOM_ACCESSES = 850;
  localparam int PLAN_ROWS = 22;

  typedef struct packed {
    logic              hit;
    logic              evicted;
    logic [KEY_W-1:0]  evicted_key;
    logic [HITS_W-1:0] hit_total;
  } access_result_t;

  typedef enum logic [1:0] {
    ROW_ACCESS,
    ROW_CAPACITY,
    ROW_HAMMER
  } row_kind_t;

  typedef struct packed {
    row_kind_t      kind;
    logic [31:0]    value;
    logic [31:0]    times;
    logic           check;
    access_result_t want;
  } plan_row_t;

  logic                    clk;
  logic                    rst = 1'b1;
  logic                    cfg_write = 1'b0;
  logic [CAP_W-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic signed [KEY_W-1:0] key = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic                    hit;
  logic                    evicted;
  logic signed [KEY_W-1:0] evicted_key;
  logic [HITS_W-1:0]       hit_total;

  // Behavioural copy of the cache.
  bit                 mdl_valid [ENTRIES];
  logic [KEY_W-1:0]   mdl_key   [ENTRIES];
  logic [CNT_W-1:0]   mdl_count [ENTRIES];
  logic [STAMP_W-1:0] mdl_stamp [ENTRIES];
  logic [STAMP_W-1:0] mdl_order = '0;
  logic [HITS_W-1:0]  mdl_hits = '0;
  logic [CAP_W-1:0]   mdl_cap = CAP_RESET;
  int                 mdl_occ = 0;

  access_result_t expected_results [$];
  bit             steady_mode = 1'b0;
  int             fail_cnt = 0;
  int             n_results = 0;
  int             n_hits = 0;
  int             n_evictions = 0;
  int             n_cfg = 0;
  int             rd_hold = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{ROW_ACCESS,   32'h8000_0000, 32'd1, 1'b1, '{1'b0, 1'b0, 32'd0, 32'd0}},
    '{ROW_ACCESS,   32'h7FFF_FFFF, 32'd1, 1'b1, '{1'b0, 1'b0, 32'd0, 32'd0}},
    '{ROW_ACCESS,   32'h0000_0000, 32'd1, 1'b1, '{1'b0, 1'b0, 32'd0, 32'd0}},
    '{ROW_ACCESS,   32'h8000_0000, 32'd1, 1'b1, '{1'b1, 1'b0, 32'd0, 32'd1}},
    '{ROW_ACCESS,   32'hFFFF_FFFF, 32'd1, 1'b1, '{1'b0, 1'b0, 32'd0, 32'd1}},
    '{ROW_ACCESS,   32'h7FFF_FFFF, 32'd1, 1'b1, '{1'b1, 1'b0, 32'd0, 32'd2}},
    // A short run of back-to-back hits on one key raises its count well clear.
    '{ROW_HAMMER,   32'h7FFF_FFFF, 32'd8, 1'b0, '0},
    // Capacity below occupancy: the count-1 key with the older stamp goes.
    '{ROW_CAPACITY, 32'd1,         32'd1, 1'b0, '0},
    '{ROW_ACCESS,   32'h0000_0005, 32'd1, 1'b1, '{1'b0, 1'b1, 32'd0, 32'd10}},
    '{ROW_ACCESS,   32'h0000_0005, 32'd1, 1'b0, '0},
    '{ROW_ACCESS,   32'hA5A5_A5A5, 32'd1, 1'b0, '0},
    '{ROW_CAPACITY, 32'd0,         32'd1, 1'b0, '0},
    '{ROW_ACCESS,   32'h5A5A_5A5A, 32'd1, 1'b0, '0},
    '{ROW_ACCESS,   32'h1234_5678, 32'd1, 1'b0, '0},
    '{ROW_CAPACITY, 32'd127,       32'd1, 1'b0, '0},
    '{ROW_ACCESS,   32'h0000_0001, 32'd1, 1'b0, '0},
    '{ROW_ACCESS,   32'h0000_0002, 32'd1, 1'b0, '0},
    '{ROW_CAPACITY, 32'd64,        32'd1, 1'b0, '0},
    '{ROW_ACCESS,   32'h8000_0000, 32'd1, 1'b0, '0},
    '{ROW_CAPACITY, 32'd2,         32'd1, 1'b0, '0},
    '{ROW_ACCESS,   32'h0000_0003, 32'd1, 1'b0, '0},
    '{ROW_ACCESS,   32'h0000_0004, 32'd1, 1'b0, '0}
  };

  lfu_cache_policy #(
    .ENTRIES(ENTRIES)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .key        (key),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .hit        (hit),
    .evicted    (evicted),
    .evicted_key(evicted_key),
    .hit_total  (hit_total)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // Updates the behavioural cache for one access and returns its result word.
  function automatic access_result_t lookup_and_update(input logic [KEY_W-1:0] k);
    access_result_t     res;
    logic [STAMP_W-1:0] stamp;
    logic [STAMP_W-1:0] age;
    logic [STAMP_W-1:0] best_age;
    logic [CNT_W-1:0]   best_cnt;
    int                 i;
    int                 match;
    int                 slot;
    int                 victim;
    int                 cap_eff;
    res = '0;
    stamp = mdl_order;
    mdl_order = mdl_order + 1'b1;
    match = -1;
    slot = -1;
    victim = -1;
    best_age = '0;
    best_cnt = '0;
    for (i = 0; i < ENTRIES; i++) begin
      if (match < 0 && mdl_valid[i] && mdl_key[i] == k) match = i;
    end
    if (match >= 0) begin
      res.hit = 1'b1;
      mdl_hits = mdl_hits + 1'b1;
      // A saturated count keeps both its value and its stamp.
      if (mdl_count[match] != COUNT_MAX) begin
        mdl_count[match] = mdl_count[match] + 1'b1;
        mdl_stamp[match] = stamp;
      end
    end else begin
      for (i = 0; i < ENTRIES; i++) begin
        if (slot < 0 && !mdl_valid[i]) slot = i;
      end
      if (mdl_cap == 0) cap_eff = 1;
      else if (mdl_cap > ENTRIES) cap_eff = ENTRIES;
      else cap_eff = int'(mdl_cap);
      if (mdl_occ >= cap_eff || slot < 0) begin
        for (i = 0; i < ENTRIES; i++) begin
          if (mdl_valid[i]) begin
            age = mdl_order - mdl_stamp[i];
            if (victim < 0 || mdl_count[i] < best_cnt ||
                (mdl_count[i] == best_cnt && age > best_age)) begin
              victim = i;
              best_cnt = mdl_count[i];
              best_age = age;
            end
          end
        end
        if (victim >= 0) begin
          res.evicted = 1'b1;
          res.evicted_key = mdl_key[victim];
          mdl_valid[victim] = 1'b0;
          if (mdl_occ > 0) mdl_occ--;
          slot = victim;
        end
      end
      if (slot >= 0) begin
        mdl_valid[slot] = 1'b1;
        mdl_key[slot] = k;
        mdl_count[slot] = COUNT_ONE;
        mdl_stamp[slot] = stamp;
        mdl_occ++;
      end
    end
    res.hit_total = mdl_hits;
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 80);
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      fail_cnt++;
    end
  endtask

  // Sends one key word; a typed expectation replaces the predicted one.
  task automatic send_key(input logic [KEY_W-1:0] k, input logic typed,
                          input access_result_t typed_res);
    access_result_t pred;
    int             gap;
    gap = steady_mode ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    key <= k;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = lookup_and_update(k);
    expected_results.push_back(typed ? typed_res : pred);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] value);
    wait_for_results();
    cfg_write <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    mdl_cap = value;
    n_cfg++;
  endtask

  // Result side: random back-pressure and the comparison of each word.
  always @(posedge clk) begin
    access_result_t want;
    int             r;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $error("result word with no access outstanding: hit %0d evicted %0d", hit,
                 evicted);
          fail_cnt++;
        end else begin
          want = expected_results.pop_front();
          check_field("hit", 32'(want.hit), 32'(hit));
          check_field("evicted", 32'(want.evicted), 32'(evicted));
          check_field("evicted_key", want.evicted_key, evicted_key);
          check_field("hit_total", want.hit_total, hit_total);
          n_results++;
          if (want.hit) n_hits++;
          if (want.evicted) n_evictions++;
        end
      end
      if (rd_hold > 0) begin
        rd_hold <= rd_hold - 1;
        out_ready <= 1'b0;
      end else if (steady_mode) begin
        out_ready <= 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          out_ready <= 1'b1;
        end else if (r < 97) begin
          out_ready <= 1'b0;
          rd_hold <= $urandom_range(0, 2);
        end else begin
          out_ready <= 1'b0;
          rd_hold <= $urandom_range(10, 100);
        end
      end
    end
  end

  initial begin
    logic [KEY_W-1:0] pool [128];
    logic [KEY_W-1:0] k;
    logic [CAP_W-1:0] cap;
    int               row;
    int               phase;
    int               issued;
    int               burst;
    int               pool_n;
    int               i;
    int               r;
    for (i = 0; i < 128; i++) pool[i] = $urandom();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (row = 0; row < PLAN_ROWS; row++) begin
      case (plan[row].kind)
        ROW_CAPACITY: begin
          set_capacity(plan[row].value[CAP_W-1:0]);
        end
        ROW_HAMMER: begin
          steady_mode = 1'b1;
          repeat (plan[row].times) send_key(plan[row].value, 1'b0, '0);
          steady_mode = 1'b0;
        end
        default: begin
          send_key(plan[row].value, plan[row].check, plan[row].want);
        end
      endcase
    end

    // Random part: each phase sets a capacity and works a skewed set of keys,
    // so that a few hot keys build up counts while the rest churn.
    issued = 0;
    phase = 0;
    while (issued < RANDOM_ACCESSES) begin
      case (phase % 8)
        0: cap = CAP_RESET;
        1: cap = 7'd1;
        2: cap = CAP_W'($urandom_range(2, 8));
        3: cap = 7'd0;
        4: cap = 7'd127;
        5: cap = CAP_W'($urandom_range(9, 63));
        6: cap = CAP_W'($urandom_range(65, 126));
        default: cap = 7'd2;
      endcase
      set_capacity(cap);
      steady_mode = (phase % 3 == 2);
      pool_n = $urandom_range(1, 100);
      for (i = 0; i < pool_n; i++) begin
        if ($urandom_range(0, 2) == 0) pool[i] = $urandom();
      end
      burst = $urandom_range(50, 110);
      while (burst > 0 && issued < RANDOM_ACCESSES) begin
        r = $urandom_range(0, 99);
        if (r < 85) begin
          k = pool[$urandom_range(0, $urandom_range(0, pool_n - 1))];
        end else if (r < 92) begin
          case ($urandom_range(0, 3))
            0: k = 32'h8000_0000;
            1: k = 32'h7FFF_FFFF;
            2: k = 32'h0000_0000;
            default: k = 32'hFFFF_FFFF;
          endcase
        end else begin
          k = $urandom();
        end
        send_key(k, 1'b0, '0);
        issued++;
        burst--;
      end
      steady_mode = 1'b0;
      phase++;
    end

    wait_for_results();
    repeat (ENTRIES + 8) @(posedge clk);
    $display("Run checked %0d result words: %0d hits and %0d evictions,", n_results,
             n_hits, n_evictions);
    $display("over %0d capacity writes including 0, 1, 64 and 127.", n_cfg);
    if (fail_cnt == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ lfu_cache_policy.f @@
rtl/core/lfu_pkg.sv
rtl/core/lfu_ram.sv
rtl/core/lfu_ctrl.sv
rtl/core/lfu_dp.sv
rtl/core/lfu_cache_policy.sv
rtl/core/lfu_chk.sv
sim/lfu_cache_policy_tb.sv
